>>> sv/tccw_pkg.sv
package tccw_pkg;

    localparam int CELL_W = 16;

    // input kinds carried on s_tuser
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    // one result item as the sequencer hands it to the output register
    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] read_data;
        logic [4:0]        cursor_row;
        logic [6:0]        cursor_col;
    } tccw_result_t;

endpackage

>>> sv/tccw_cell_store.sv
module tccw_cell_store
    import tccw_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tccw_ctrl.sv
module tccw_ctrl
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_cmd,
    input  logic [7:0]                           in_char,
    input  logic [10:0]                          in_addr,
    input  logic [7:0]                           text_color,
    input  logic                                 slot_free,
    output logic                                 mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      mem_waddr,
    output logic [CELL_W-1:0]                    mem_wdata,
    output logic                                 mem_re,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      mem_raddr,
    input  logic [CELL_W-1:0]                    mem_rdata,
    output tccw_result_t                         res
);

    localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int CW  = $clog2(CELL_COUNT + 1);
    localparam int RW  = $clog2(ROWS + 1);
    localparam int CLW = $clog2(COLUMNS + 1);
    localparam int KEEP = (ROWS - 1) * COLUMNS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_SCROLL,
        ST_FILL,
        ST_RD_DATA,
        ST_OUT_WAIT
    } state_t;

    state_t         state_reg, state_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CLW-1:0] col_reg, col_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           pend_reg, pend_next;
    logic [7:0]     char_reg, char_next;
    logic           addr_ok_reg, addr_ok_next;

    logic           wrap;
    logic [RW-1:0]  row_w;
    logic [CLW-1:0] col_w;
    logic           addr_ok;

    assign wrap    = (col_reg >= CLW'(COLUMNS));
    assign row_w   = wrap ? row_reg + RW'(1) : row_reg;
    assign col_w   = wrap ? '0 : col_reg;
    assign addr_ok = (32'(in_addr) < CELL_COUNT);

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        char_next    = char_reg;
        addr_ok_next = addr_ok_reg;
        in_ready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        res          = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                mem_wdata = {RESET_COLOR, BLANK_CHAR};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_cmd == CMD_READ) begin
                        mem_re       = addr_ok;
                        mem_raddr    = AW'(in_addr);
                        addr_ok_next = addr_ok;
                        state_next   = ST_RD_DATA;
                    end else begin
                        char_next  = in_char;
                        state_next = ST_PUT;
                    end
                end
            end
            ST_PUT: begin
                if (row_w >= RW'(ROWS)) begin
                    // overflow past the last row: scroll first, then come back
                    row_next   = RW'(ROWS - 1);
                    col_next   = col_w;
                    cnt_next   = CW'(COLUMNS);
                    state_next = ST_SCROLL;
                end else begin
                    if (char_reg == NEWLINE_CHAR) begin
                        row_next = row_w + RW'(1);
                        col_next = '0;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(row_w * COLUMNS + col_w);
                        mem_wdata = {text_color, char_reg};
                        row_next  = row_w;
                        col_next  = col_w + CLW'(1);
                    end
                    if (slot_free) begin
                        res.valid      = 1'b1;
                        res.cursor_row = 5'(row_next);
                        res.cursor_col = 7'(col_next);
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_OUT_WAIT;
                    end
                end
            end
            ST_SCROLL: begin
                // read one row ahead, write the previous read one row up
                if (cnt_reg < CW'(CELL_COUNT)) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg[AW-1:0];
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                end
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(cnt_reg - CW'(COLUMNS + 1));
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == CW'(CELL_COUNT)) begin
                    cnt_next   = CW'(KEEP);
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                mem_wdata = {text_color, BLANK_CHAR};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(CELL_COUNT - 1)) begin
                    state_next = ST_PUT;
                end
            end
            ST_RD_DATA: begin
                if (slot_free) begin
                    res.valid      = 1'b1;
                    res.read_data  = addr_ok_reg ? mem_rdata : '0;
                    res.cursor_row = 5'(row_reg);
                    res.cursor_col = 7'(col_reg);
                    state_next     = ST_IDLE;
                end
            end
            ST_OUT_WAIT: begin
                if (slot_free) begin
                    res.valid      = 1'b1;
                    res.cursor_row = 5'(row_reg);
                    res.cursor_col = 7'(col_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
        char_reg    <= char_next;
        addr_ok_reg <= addr_ok_next;
    end

    a_cursor_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg <= RW'(ROWS)) && (col_reg <= CLW'(COLUMNS)))
        else $error("cursor beyond pending wrap or overflow position");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("cell store written while idle");

    a_copy_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("scroll copy reads and writes the same cell");

    a_result_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> (state_reg == ST_IDLE))
        else $error("result issued without returning to idle");

endmodule

>>> sv/text_console_cell_writer.sv
// text console cell writer: a ROWS x COLUMNS store of 16-bit cells
// (char in the low byte, attribute above) with a cursor that wraps and scrolls
//
// s_ channel: one item per command. s_tuser selects put (0) or read (1);
// a put writes char_code at the cursor (newline moves to the next row),
// a read returns one cell. every item gives exactly one m_ item carrying
// read data (zero for put) and the cursor after the command
// cfg_we/cfg_wdata set the attribute used for new cells, write only when idle
//
// timing: after the accept, a read fetches its cell through the registered
// store port and a plain put writes its cell; the result then goes to the
// output register as soon as that is free, and the next item is taken once
// the result is issued. a put that overflows the last row first scrolls the
// store through its single port pair: overflow check, row copy, bottom row fill
// reset clears every cell to space grey on black, one cell a cycle, so
// s_tready stays low through the whole clearing pass after aresetn rises
// a stalled m_ side keeps its item in the output register; the block still
// takes the next item and holds that result until the register frees up
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code [7:0], cell_address [18:8], zero above
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data [15:0], cursor_row [20:16],
                                   // cursor_col [27:21], zero above
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // attribute register for new cells
    logic [7:0] text_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= RESET_COLOR;
        end else if (cfg_we) begin
            text_color_reg <= cfg_wdata;
        end
    end

    // cell store ports driven by the sequencer
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tccw_result_t res;
    logic         slot_free;

    tccw_cell_store #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tccw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_char    (s_tdata[7:0]),
        .in_addr    (s_tdata[18:8]),
        .text_color (text_color_reg),
        .slot_free  (slot_free),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .res        (res)
    );

    // output register, parts the sequencer from a stalled receiver
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign slot_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_tdata_reg <= {4'b0000, res.cursor_col, res.cursor_row, res.read_data};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/sv/text_console_cell_writer_tb.sv
module text_console_cell_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    // screen geometry of the instance under test
    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    // cycles with no item moving on either side before the run is abandoned;
    // covers the clearing pass, a full scroll and the long receiver hold-off
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 120;   // results seen before the hold-off
    localparam int PHASE_ITEMS    = 195;
    localparam int DIRECTED_COUNT = 21;

    // one result item, fields as they travel on m_tdata
    typedef struct packed {
        logic [15:0] data;
        logic [4:0]  row;
        logic [6:0]  col;
    } cell_result_t;

    // one row of the directed stimulus; the result is typed in where has_result is set
    typedef struct packed {
        logic         cmd;
        logic [7:0]   ch;
        logic [10:0]  addr;
        logic         has_result;
        cell_result_t result;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    text_console_cell_writer #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the console: cell store, cursor and attribute
    logic [15:0]   shadow_screen [0:SCREEN_CELLS-1];
    int            cur_row;
    int            cur_col;
    logic [7:0]    shadow_color;

    cell_result_t  pending_results [$];
    directed_row_t directed_rows [0:DIRECTED_COUNT-1];
    cell_result_t  got;
    cell_result_t  want;
    int            mismatch_count;
    int            results_seen;
    int            quiet_cycles;
    bit            calm;   // no idling on either side while set

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // --------------------------------------------------------------------
    // predictor: applies one accepted item to the shadow console
    // --------------------------------------------------------------------
    task automatic console_step(input logic cmd, input logic [7:0] ch,
                                input logic [10:0] addr, output cell_result_t res);
        int idx;
        res = '0;
        if (cmd == CMD_READ) begin
            // out-of-range reads give zero, cursor stays put
            if (addr < SCREEN_CELLS) begin
                res.data = shadow_screen[addr];
            end
        end else begin
            // pending wrap first
            if (cur_col >= SCREEN_COLS) begin
                cur_col = 0;
                cur_row++;
            end
            // then pending overflow: scroll up, bottom row blank in current color
            if (cur_row >= SCREEN_ROWS) begin
                cur_row = SCREEN_ROWS - 1;
                for (idx = 0; idx < SCREEN_CELLS; idx++) begin
                    if (idx < SCREEN_CELLS - SCREEN_COLS) begin
                        shadow_screen[idx] = shadow_screen[idx + SCREEN_COLS];
                    end else begin
                        shadow_screen[idx] = {shadow_color, BLANK_CHAR};
                    end
                end
            end
            if (ch == NEWLINE_CHAR) begin
                cur_col = 0;
                cur_row++;
            end else begin
                idx = cur_row * SCREEN_COLS + cur_col;
                if (idx < SCREEN_CELLS) begin
                    shadow_screen[idx] = {shadow_color, ch};
                end
                cur_col++;
            end
        end
        res.row = cur_row[4:0];
        res.col = cur_col[6:0];
    endtask

    task automatic flag_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got_v, want_v, $time);
        mismatch_count++;
    endtask

    // --------------------------------------------------------------------
    // sender: offers one item, idling at random unless calm, and records
    // the expected result once the item is accepted
    // --------------------------------------------------------------------
    task automatic offer_item(input logic cmd, input logic [7:0] ch, input logic [10:0] addr,
                              input logic has_result, input cell_result_t typed);
        cell_result_t res;
        while (!calm && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, addr, ch};
        do @(posedge aclk); while (!s_tready);
        console_step(cmd, ch, addr, res);
        // typed rows must agree with the predictor too, they are simply read off by eye
        pending_results.push_back(has_result ? typed : res);
        @(negedge aclk);
    endtask

    // attribute write, only once every result is back and the block is quiet
    task automatic set_text_color(input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        shadow_color = value;
    endtask

    // read address: anywhere, the bottom row, the top edge of the range, or near the cursor
    function automatic logic [10:0] pick_read_addr();
        int r;
        r = $urandom_range(3);
        case (r)
            0: begin
                return 11'($urandom_range(2047));
            end
            1: begin
                return 11'($urandom_range(SCREEN_CELLS - 1, SCREEN_CELLS - SCREEN_COLS));
            end
            2: begin
                return 11'($urandom_range(2047, SCREEN_CELLS - 10));
            end
            default: begin
                return 11'(((cur_row < SCREEN_ROWS) ? cur_row : SCREEN_ROWS - 1) * SCREEN_COLS
                           + $urandom_range(SCREEN_COLS - 1));
            end
        endcase
    endfunction

    // --------------------------------------------------------------------
    // receiver: random stalls, one long hold-off so the block backs up
    // --------------------------------------------------------------------
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 31);
            end
        end
    end

    // result checker, field by field against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got = {m_tdata[15:0], m_tdata[20:16], m_tdata[27:21]};
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data) flag_mismatch("read_data", got.data, want.data);
                if (got.row !== want.row) flag_mismatch("cursor_row", got.row, want.row);
                if (got.col !== want.col) flag_mismatch("cursor_col", got.col, want.col);
            end
        end
    end

    // watchdog: nothing accepted on either side for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    // --------------------------------------------------------------------
    // main stimulus
    // --------------------------------------------------------------------
    initial begin
        int           i;
        int           phase;
        int           phase_start;
        int           line_len;
        int           r;
        logic [7:0]   ch;
        logic [7:0]   phase_colors [0:3];

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = CMD_PUT;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        calm           = 0;
        mismatch_count = 0;
        results_seen   = 0;

        // shadow state after reset
        for (i = 0; i < SCREEN_CELLS; i++) shadow_screen[i] = {RESET_COLOR, BLANK_CHAR};
        cur_row      = 0;
        cur_col      = 0;
        shadow_color = RESET_COLOR;

        // directed items: cmd, char, address, typed?, {data, row, col}
        directed_rows = '{
            // fresh screen: first and last cell, then both out-of-range extremes
            '{CMD_READ, 8'h00, 11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0}},
            '{CMD_READ, 8'hFF, 11'd1999, 1'b1, '{16'h0720, 5'd0, 7'd0}},
            '{CMD_READ, 8'h00, 11'd2000, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{CMD_READ, 8'hAA, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            // puts ignore the address, extremes of the character byte
            '{CMD_PUT,  8'h41, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd1}},
            '{CMD_PUT,  8'h00, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd2}},
            '{CMD_PUT,  8'hFF, 11'h555,  1'b1, '{16'h0000, 5'd0, 7'd3}},
            // reads ignore the character, even a newline
            '{CMD_READ, NEWLINE_CHAR, 11'd0, 1'b1, '{16'h0741, 5'd0, 7'd3}},
            '{CMD_READ, 8'h55, 11'd2,    1'b1, '{16'h07FF, 5'd0, 7'd3}},
            // newline, twice in a row
            '{CMD_PUT,  NEWLINE_CHAR, 11'h2AA, 1'b1, '{16'h0000, 5'd1, 7'd0}},
            '{CMD_PUT,  NEWLINE_CHAR, 11'd0,   1'b1, '{16'h0000, 5'd2, 7'd0}},
            '{CMD_PUT,  8'h7A, 11'h7FF,  1'b1, '{16'h0000, 5'd2, 7'd1}},
            '{CMD_READ, 8'h00, 11'd160,  1'b1, '{16'h077A, 5'd2, 7'd1}},
            '{CMD_READ, 8'h00, 11'd1,    1'b1, '{16'h0700, 5'd2, 7'd1}},
            // control-like bytes next to newline are plain characters
            '{CMD_PUT,  8'h09, 11'd5,    1'b0, '0},
            '{CMD_PUT,  8'h0B, 11'd1024, 1'b0, '0},
            '{CMD_PUT,  8'h80, 11'h2AA,  1'b0, '0},
            '{CMD_PUT,  8'h7F, 11'h555,  1'b0, '0},
            '{CMD_READ, 8'h20, 11'h2AA,  1'b0, '0},
            '{CMD_READ, 8'h00, 11'd163,  1'b0, '0},
            '{CMD_READ, 8'h0A, 11'd1999, 1'b0, '0}
        };

        phase_colors[0] = 8'h00;
        phase_colors[1] = 8'hFF;
        phase_colors[2] = 8'($urandom_range(255));
        phase_colors[3] = 8'h1E;

        // synchronous reset, released on a falling edge; the block then clears its store
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < DIRECTED_COUNT; i++) begin
            offer_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].addr,
                       directed_rows[i].has_result, directed_rows[i].result);
        end

        // random phases, each under its own attribute; phase 2 runs with no idling
        for (phase = 0; phase < 4; phase++) begin
            set_text_color(phase_colors[phase]);
            calm = (phase == 2);
            phase_start = results_seen + pending_results.size();
            while (results_seen + pending_results.size() - phase_start < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 50) begin
                    // a text line: mostly short, sometimes right at the wrap point,
                    // so wrap-then-newline and wrap into scroll both come up
                    line_len = ($urandom_range(7) == 0) ? $urandom_range(82, 78)
                                                        : $urandom_range(12);
                    repeat (line_len) begin
                        ch = 8'($urandom_range(255));
                        if (ch == NEWLINE_CHAR) ch = BLANK_CHAR;
                        offer_item(CMD_PUT, ch, 11'($urandom_range(2047)), 1'b0, '0);
                    end
                    offer_item(CMD_PUT, NEWLINE_CHAR, 11'($urandom_range(2047)), 1'b0, '0);
                end else if (r < 82) begin
                    offer_item(CMD_READ, 8'($urandom_range(255)), pick_read_addr(), 1'b0, '0);
                end else begin
                    // noise: any byte, newline included
                    ch = ($urandom_range(3) == 0) ? NEWLINE_CHAR : 8'($urandom_range(255));
                    offer_item(CMD_PUT, ch, 11'($urandom_range(2047)), 1'b0, '0);
                end
            end
        end

        // drain, then let the block settle
        s_tvalid <= 1'b0;
        calm = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/tccw_pkg.sv
sv/tccw_cell_store.sv
sv/tccw_ctrl.sv
sv/text_console_cell_writer.sv
tb/sv/text_console_cell_writer_tb.sv
